// ===== src/rhsm_pkg.sv =====
// Shared types and constants for the resolve history swap matcher.
// No dependencies; used by rhsm_ring and the top level.
`default_nettype none

package rhsm_pkg;

   localparam int WORD_W             = 32;
   localparam int SEQ_W              = 48;
   localparam int MAX_DESC_WORDS     = 6;
   localparam int HISTORY_DEPTH_DEF  = 64;
   localparam int DESC_WORDS_DEF     = 6;

   localparam logic [SEQ_W-1:0]  SEQ_MAX   = {SEQ_W{1'b1}};
   localparam logic [WORD_W-1:0] BASE_MASK = 32'hFFFF_F000;

   // request codes
   localparam logic [1:0] REQ_RESOLVE = 2'd0;
   localparam logic [1:0] REQ_SWAP    = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // match kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_EXACT = 2'd1;
   localparam logic [1:0] KIND_BASE  = 2'd2;

   // per-record side data
   typedef struct packed {
      logic [WORD_W-1:0] call_addr;
      logic [WORD_W-1:0] flags;
      logic [3:0]        mip_lvl;
      logic [11:0]       slice_index;
   } meta_type;

   // compare result of one ring entry
   typedef struct packed {
      logic             vld;
      logic             exact;
      logic             base;
      logic [SEQ_W-1:0] seq;
   } hit_type;

endpackage

`default_nettype wire

// ===== src/rhsm_ring.sv =====
// History ring storage with a registered read port and the shared entry comparator.
// Depends on rhsm_pkg.
`default_nettype none

module rhsm_ring #(
   parameter int HISTORY_DEPTH = rhsm_pkg::HISTORY_DEPTH_DEF,
   parameter int DESC_WORDS    = rhsm_pkg::DESC_WORDS_DEF,
   localparam int SLOT_W       = $clog2(HISTORY_DEPTH)
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      wr_en,
   input  wire logic [SLOT_W-1:0]                         wr_slot,
   input  wire logic [DESC_WORDS-1:0][rhsm_pkg::WORD_W-1:0] wr_desc,
   input  wire rhsm_pkg::meta_type                        wr_meta,
   input  wire logic                                      rd_en,
   input  wire logic [SLOT_W-1:0]                         rd_slot,
   input  wire logic [rhsm_pkg::SEQ_W-1:0]                rd_seq,
   input  wire logic [DESC_WORDS-1:0][rhsm_pkg::WORD_W-1:0] query_desc,
   output rhsm_pkg::hit_type                              hit,
   output rhsm_pkg::meta_type                             hit_meta
);

   logic [DESC_WORDS-1:0][rhsm_pkg::WORD_W-1:0] desc_mem [HISTORY_DEPTH];
   rhsm_pkg::meta_type                          meta_mem [HISTORY_DEPTH];

   logic [DESC_WORDS-1:0][rhsm_pkg::WORD_W-1:0] rd_desc_ff;
   rhsm_pkg::meta_type                          rd_meta_ff;
   logic [rhsm_pkg::SEQ_W-1:0]                  rd_seq_ff;
   logic                                        rd_vld_ff;
   logic                                        rd_vld_in;

   logic                        same;
   logic [rhsm_pkg::WORD_W-1:0] want_base;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         desc_mem[wr_slot] <= wr_desc;
         meta_mem[wr_slot] <= wr_meta;
      end
      if (rd_en) begin
         rd_desc_ff <= desc_mem[rd_slot];
         rd_meta_ff <= meta_mem[rd_slot];
         rd_seq_ff  <= rd_seq;
      end
   end

   assign rd_vld_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
   end

   // exact and page-base compare on the entry just read
   always_comb begin
      same = 1'b1;
      for (int w = 0; w < DESC_WORDS; w++) begin
         if (rd_desc_ff[w] != query_desc[w]) begin
            same = 1'b0;
         end
      end
   end

   assign want_base = query_desc[1] & rhsm_pkg::BASE_MASK;

   always_comb begin
      hit.vld   = rd_vld_ff;
      hit.exact = same;
      hit.base  = (want_base != '0) &&
                  ((rd_desc_ff[1] & rhsm_pkg::BASE_MASK) == want_base);
      hit.seq   = rd_seq_ff;
   end

   assign hit_meta = rd_meta_ff;

endmodule

`default_nettype wire

// ===== src/resolve_history_swap_matcher_core.sv =====
// Top level of the resolve history swap matcher: sequencer, counters, response register.
// Depends on rhsm_pkg and rhsm_ring.
`default_nettype none

// Channel   Dir  Handshake            Payload
// req_*     in   req_valid/req_ready  req_type, desc words 0..5, call, flags, mip, slice
// rsp_*     out  rsp_valid/rsp_ready  seqs, match kind and record, three swap counters
//
// One request at a time. Resolve, clear and unused codes go IDLE, EXEC, DONE,
// IDLE. A swap adds a SEARCH walk of up to N = min(resolves since the last
// swap, HISTORY_DEPTH) entries: the ring has one read port, walked newest
// first one entry per cycle through a registered read; an exact hit ends the walk.
// Reset (synchronous) clears counters and sequencer; ring contents need none,
// since a walk only visits entries written since the last clear.
// The response register lets the next request start while a response waits;
// a finished request holds in DONE until the response register is free.

module resolve_history_swap_matcher_core #(
   parameter int HISTORY_DEPTH = rhsm_pkg::HISTORY_DEPTH_DEF,
   parameter int DESC_WORDS    = rhsm_pkg::DESC_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_desc_word0,
   input  wire logic [31:0] req_desc_word1,
   input  wire logic [31:0] req_desc_word2,
   input  wire logic [31:0] req_desc_word3,
   input  wire logic [31:0] req_desc_word4,
   input  wire logic [31:0] req_desc_word5,
   input  wire logic [31:0] req_call_addr,
   input  wire logic [31:0] req_resolve_flags,
   input  wire logic [3:0]  req_mip_lvl,
   input  wire logic [11:0] req_slice_index,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [47:0]      rsp_resolve_seq,
   output logic [47:0]      rsp_swap_seq,
   output logic [1:0]       rsp_match_kind,
   output logic [31:0]      rsp_match_call_addr,
   output logic [31:0]      rsp_match_flags,
   output logic [3:0]       rsp_match_mip_lvl,
   output logic [11:0]      rsp_match_slice,
   output logic [47:0]      rsp_exact_count,
   output logic [47:0]      rsp_candidate_total,
   output logic [47:0]      rsp_unmatched_total
);

   localparam int SEQ_W  = rhsm_pkg::SEQ_W;
   localparam int WORD_W = rhsm_pkg::WORD_W;
   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   function automatic logic [SEQ_W-1:0] sat_inc(input logic [SEQ_W-1:0] v);
      return (v == rhsm_pkg::SEQ_MAX) ? v : v + SEQ_W'(1);
   endfunction

   // sequencer and request latch
   state_type                            state_ff, state_in;
   logic [1:0]                           q_type_ff, q_type_in;
   logic [DESC_WORDS-1:0][WORD_W-1:0]    q_desc_ff, q_desc_in;
   rhsm_pkg::meta_type                   q_meta_ff, q_meta_in;

   // sequence and swap counters
   logic [SEQ_W-1:0]  rc_ff, rc_in;
   logic [SLOT_W-1:0] rc_slot_ff, rc_slot_in;
   logic [SEQ_W-1:0]  last_ff, last_in;
   logic [SEQ_W-1:0]  swap_ctr_ff, swap_ctr_in;
   logic [SEQ_W-1:0]  exact_ctr_ff, exact_ctr_in;
   logic [SEQ_W-1:0]  cand_ctr_ff, cand_ctr_in;
   logic [SEQ_W-1:0]  unm_ctr_ff, unm_ctr_in;

   // walk state
   logic [SLOT_W-1:0]  scan_slot_ff, scan_slot_in;
   logic [SEQ_W-1:0]   scan_seq_ff, scan_seq_in;
   logic [CNT_W-1:0]   scan_left_ff, scan_left_in;
   logic               have_exact_ff, have_exact_in;
   logic               have_base_ff, have_base_in;
   logic [SEQ_W-1:0]   match_seq_ff, match_seq_in;
   rhsm_pkg::meta_type match_meta_ff, match_meta_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]   rsp_resolve_seq_ff, rsp_resolve_seq_in;
   logic [SEQ_W-1:0]   rsp_swap_seq_ff, rsp_swap_seq_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   rhsm_pkg::meta_type rsp_meta_ff, rsp_meta_in;
   logic [SEQ_W-1:0]   rsp_exact_ff, rsp_exact_in;
   logic [SEQ_W-1:0]   rsp_cand_ff, rsp_cand_in;
   logic [SEQ_W-1:0]   rsp_unm_ff, rsp_unm_in;

   // ring port
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_slot;
   logic                   rd_en;
   rhsm_pkg::hit_type      hit;
   rhsm_pkg::meta_type     hit_meta;

   logic [rhsm_pkg::MAX_DESC_WORDS-1:0][WORD_W-1:0] req_words;
   logic [SEQ_W-1:0]  diff;
   logic              exact_now;
   logic              base_now;
   logic              fire;
   logic [1:0]        kind;

   assign req_words = {req_desc_word5, req_desc_word4, req_desc_word3,
                       req_desc_word2, req_desc_word1, req_desc_word0};

   assign req_ready = (state_ff == ST_IDLE);
   assign diff      = rc_ff - last_ff;
   assign exact_now = hit.vld && hit.exact;
   assign base_now  = hit.vld && !hit.exact && hit.base && !have_base_ff;
   assign fire      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (q_type_ff != rhsm_pkg::REQ_SWAP) begin
         kind = rhsm_pkg::KIND_NONE;
      end else if (have_exact_ff) begin
         kind = rhsm_pkg::KIND_EXACT;
      end else if (have_base_ff) begin
         kind = rhsm_pkg::KIND_BASE;
      end else begin
         kind = rhsm_pkg::KIND_NONE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      q_type_in     = q_type_ff;
      q_desc_in     = q_desc_ff;
      q_meta_in     = q_meta_ff;
      rc_in         = rc_ff;
      rc_slot_in    = rc_slot_ff;
      last_in       = last_ff;
      swap_ctr_in   = swap_ctr_ff;
      exact_ctr_in  = exact_ctr_ff;
      cand_ctr_in   = cand_ctr_ff;
      unm_ctr_in    = unm_ctr_ff;
      scan_slot_in  = scan_slot_ff;
      scan_seq_in   = scan_seq_ff;
      scan_left_in  = scan_left_ff;
      have_exact_in = have_exact_ff;
      have_base_in  = have_base_ff;
      match_seq_in  = match_seq_ff;
      match_meta_in = match_meta_ff;
      wr_en         = 1'b0;
      wr_slot       = rc_slot_ff;
      rd_en         = 1'b0;

      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_resolve_seq_in = rsp_resolve_seq_ff;
      rsp_swap_seq_in    = rsp_swap_seq_ff;
      rsp_kind_in        = rsp_kind_ff;
      rsp_meta_in        = rsp_meta_ff;
      rsp_exact_in       = rsp_exact_ff;
      rsp_cand_in        = rsp_cand_ff;
      rsp_unm_in         = rsp_unm_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               q_type_in = req_type;
               for (int w = 0; w < DESC_WORDS; w++) begin
                  q_desc_in[w] = req_words[w];
               end
               q_meta_in.call_addr   = req_call_addr;
               q_meta_in.flags       = req_resolve_flags;
               q_meta_in.mip_lvl     = req_mip_lvl;
               q_meta_in.slice_index = req_slice_index;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (q_type_ff)
               rhsm_pkg::REQ_RESOLVE: begin
                  // saturated counter keeps rewriting its own slot
                  if (rc_ff != rhsm_pkg::SEQ_MAX) begin
                     rc_in   = rc_ff + SEQ_W'(1);
                     wr_slot = (rc_slot_ff == LAST_SLOT) ? '0 : rc_slot_ff + SLOT_W'(1);
                  end
                  wr_en      = 1'b1;
                  rc_slot_in = wr_slot;
               end
               rhsm_pkg::REQ_SWAP: begin
                  swap_ctr_in   = sat_inc(swap_ctr_ff);
                  scan_slot_in  = rc_slot_ff;
                  scan_seq_in   = rc_ff;
                  scan_left_in  = (diff >= SEQ_W'(HISTORY_DEPTH)) ?
                                  CNT_W'(HISTORY_DEPTH) : diff[CNT_W-1:0];
                  have_exact_in = 1'b0;
                  have_base_in  = 1'b0;
                  state_in      = ST_SEARCH;
               end
               rhsm_pkg::REQ_CLEAR: begin
                  rc_in        = '0;
                  rc_slot_in   = LAST_SLOT;
                  last_in      = '0;
                  swap_ctr_in  = '0;
                  exact_ctr_in = '0;
                  cand_ctr_in  = '0;
                  unm_ctr_in   = '0;
               end
               default: begin
               end
            endcase
         end
         ST_SEARCH: begin
            // issue one read per cycle, compare the one read last cycle
            if (scan_left_ff != '0 && !exact_now) begin
               rd_en        = 1'b1;
               scan_slot_in = (scan_slot_ff == '0) ? LAST_SLOT : scan_slot_ff - SLOT_W'(1);
               scan_seq_in  = scan_seq_ff - SEQ_W'(1);
               scan_left_in = scan_left_ff - CNT_W'(1);
            end
            if (exact_now || base_now) begin
               match_seq_in  = hit.seq;
               match_meta_in = hit_meta;
            end
            if (exact_now) begin
               have_exact_in = 1'b1;
            end
            if (base_now) begin
               have_base_in = 1'b1;
            end
            // with nothing left to issue, this cycle compares the last entry
            if (exact_now || scan_left_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (fire) begin
               rsp_valid_in       = 1'b1;
               rsp_kind_in        = kind;
               rsp_swap_seq_in    = '0;
               rsp_resolve_seq_in = '0;
               rsp_meta_in        = '0;
               rsp_exact_in       = exact_ctr_ff;
               rsp_cand_in        = cand_ctr_ff;
               rsp_unm_in         = unm_ctr_ff;
               if (q_type_ff == rhsm_pkg::REQ_RESOLVE) begin
                  rsp_resolve_seq_in = rc_ff;
               end
               if (q_type_ff == rhsm_pkg::REQ_SWAP) begin
                  rsp_swap_seq_in = swap_ctr_ff;
                  last_in         = rc_ff;
                  if (kind != rhsm_pkg::KIND_NONE) begin
                     rsp_resolve_seq_in = match_seq_ff;
                     rsp_meta_in        = match_meta_ff;
                  end
                  case (kind)
                     rhsm_pkg::KIND_EXACT: begin
                        exact_ctr_in = sat_inc(exact_ctr_ff);
                        rsp_exact_in = exact_ctr_in;
                     end
                     rhsm_pkg::KIND_BASE: begin
                        cand_ctr_in = sat_inc(cand_ctr_ff);
                        rsp_cand_in = cand_ctr_in;
                     end
                     default: begin
                        unm_ctr_in = sat_inc(unm_ctr_ff);
                        rsp_unm_in = unm_ctr_in;
                     end
                  endcase
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rc_ff         <= '0;
         rc_slot_ff    <= LAST_SLOT;
         last_ff       <= '0;
         swap_ctr_ff   <= '0;
         exact_ctr_ff  <= '0;
         cand_ctr_ff   <= '0;
         unm_ctr_ff    <= '0;
         scan_left_ff  <= '0;
         have_exact_ff <= 1'b0;
         have_base_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rc_ff         <= rc_in;
         rc_slot_ff    <= rc_slot_in;
         last_ff       <= last_in;
         swap_ctr_ff   <= swap_ctr_in;
         exact_ctr_ff  <= exact_ctr_in;
         cand_ctr_ff   <= cand_ctr_in;
         unm_ctr_ff    <= unm_ctr_in;
         scan_left_ff  <= scan_left_in;
         have_exact_ff <= have_exact_in;
         have_base_ff  <= have_base_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_type_ff          <= q_type_in;
      q_desc_ff          <= q_desc_in;
      q_meta_ff          <= q_meta_in;
      scan_slot_ff       <= scan_slot_in;
      scan_seq_ff        <= scan_seq_in;
      match_seq_ff       <= match_seq_in;
      match_meta_ff      <= match_meta_in;
      rsp_resolve_seq_ff <= rsp_resolve_seq_in;
      rsp_swap_seq_ff    <= rsp_swap_seq_in;
      rsp_kind_ff        <= rsp_kind_in;
      rsp_meta_ff        <= rsp_meta_in;
      rsp_exact_ff       <= rsp_exact_in;
      rsp_cand_ff        <= rsp_cand_in;
      rsp_unm_ff         <= rsp_unm_in;
   end

   rhsm_ring #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .DESC_WORDS    (DESC_WORDS)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_slot    (wr_slot),
      .wr_desc    (q_desc_ff),
      .wr_meta    (q_meta_ff),
      .rd_en      (rd_en),
      .rd_slot    (scan_slot_ff),
      .rd_seq     (scan_seq_ff),
      .query_desc (q_desc_ff),
      .hit        (hit),
      .hit_meta   (hit_meta)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_resolve_seq     = rsp_resolve_seq_ff;
   assign rsp_swap_seq        = rsp_swap_seq_ff;
   assign rsp_match_kind      = rsp_kind_ff;
   assign rsp_match_call_addr = rsp_meta_ff.call_addr;
   assign rsp_match_flags     = rsp_meta_ff.flags;
   assign rsp_match_mip_lvl   = rsp_meta_ff.mip_lvl;
   assign rsp_match_slice     = rsp_meta_ff.slice_index;
   assign rsp_exact_count     = rsp_exact_ff;
   assign rsp_candidate_total = rsp_cand_ff;
   assign rsp_unmatched_total = rsp_unm_ff;

   // the last swap point never runs ahead of the resolve counter
   a_last_le_rc: assert property (@(posedge clock) disable iff (reset)
      last_ff <= rc_ff)
      else $error("swap point ahead of resolve counter");

   // a walk never covers more than the ring holds
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      scan_left_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("walk length exceeds ring depth");

   // a response only appears when a finished request hands off
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside hand-off");

   // a finished swap moves the swap point up to the resolve counter
   a_swap_mark: assert property (@(posedge clock) disable iff (reset)
      (fire && q_type_ff == rhsm_pkg::REQ_SWAP) |=> (last_ff == rc_ff))
      else $error("swap point not updated");

endmodule

`default_nettype wire
